// ===== rtl/core/shbh_pkg.sv =====
`timescale 1ns / 1ps
package shbh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } q_item_t;

    localparam logic [255:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [3:0] LEN_HI_WORD = 4'd14;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/shbh_stream_if.sv =====
`timescale 1ns / 1ps
interface shbh_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sha256_byte_hasher_top.sv =====
`timescale 1ns / 1ps
// SHA-256 over a byte stream. A message byte is taken while the packer is not padding and the
// two-word queue between the byte packer and the compression engine has room. Per block the
// engine does 16 word loads, 64 rounds at one round a cycle and one feed-forward add, but
// while it compresses the packer can only fill the queue with 8 bytes, and the other 56 bytes
// then arrive one per cycle. Message end adds 3 to 18 padding words from the packer, one per
// cycle while the queue has room, one or two block compressions, and eight digest words, high
// word first, one per cycle as the sink takes them.
module sha256_byte_hasher_top
    import shbh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    shbh_stream_if.sink   msg,
    shbh_stream_if.source digest
);

    shbh_stream_if #(.T(q_item_t)) q_wr ();
    shbh_stream_if #(.T(q_item_t)) q_rd ();

    shbh_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .q     (q_wr)
    );

    shbh_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .rd    (q_rd)
    );

    shbh_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q      (q_rd),
        .digest (digest)
    );

endmodule

// ===== rtl/core/shbh_front.sv =====
`timescale 1ns / 1ps
module shbh_front
    import shbh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    shbh_stream_if.sink   msg,
    shbh_stream_if.source q
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_FIRST = 3'd1;
    localparam logic [2:0] F_ZERO  = 3'd2;
    localparam logic [2:0] F_LENHI = 3'd3;
    localparam logic [2:0] F_LENLO = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [23:0] acc_reg, acc_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [3:0]  widx_inc;
    logic [31:0] first_word;
    in_item_t    item;

    assign item     = msg.payload;
    assign widx_inc = fill_reg[5:2] + 4'd1;

    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    first_word = 32'h8000_0000;
            2'd1:    first_word = {acc_reg[7:0], 8'h80, 16'h0};
            2'd2:    first_word = {acc_reg[15:0], 8'h80, 8'h0};
            default: first_word = {acc_reg[23:0], 8'h80};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        msg.ready  = (state_reg == F_IDLE) && q.ready;
        q.valid    = 1'b0;
        q.payload  = '{word: 32'h0, last: 1'b0};
        unique case (state_reg)
            F_IDLE:
            begin
                if (msg.valid && msg.ready)
                begin
                    if (item.byte_valid)
                    begin
                        acc_next  = {acc_reg[15:0], item.data_byte};
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            q.valid   = 1'b1;
                            q.payload = '{word: {acc_reg, item.data_byte}, last: 1'b0};
                        end
                    end
                    if (item.message_end)
                    begin
                        state_next = F_FIRST;
                    end
                end
            end
            F_FIRST, F_ZERO:
            begin
                q.valid   = 1'b1;
                q.payload = '{word: (state_reg == F_FIRST) ? first_word : 32'h0,
                              last: 1'b0};
                if (q.ready)
                begin
                    fill_next  = {widx_inc, 2'b00};
                    state_next = (widx_inc == LEN_HI_WORD) ? F_LENHI : F_ZERO;
                end
            end
            F_LENHI:
            begin
                q.valid   = 1'b1;
                q.payload = '{word: bits_reg[63:32], last: 1'b0};
                if (q.ready)
                begin
                    fill_next  = {widx_inc, 2'b00};
                    state_next = F_LENLO;
                end
            end
            F_LENLO:
            begin
                q.valid   = 1'b1;
                q.payload = '{word: bits_reg[31:0], last: 1'b1};
                if (q.ready)
                begin
                    fill_next  = 6'd0;
                    bits_next  = 64'd0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

// ===== rtl/core/shbh_fifo.sv =====
`timescale 1ns / 1ps
module shbh_fifo
    import shbh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    shbh_stream_if.sink   wr,
    shbh_stream_if.source rd
);

    q_item_t    mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr.ready   = (cnt_reg != 2'd2);
    assign rd.valid   = (cnt_reg != 2'd0);
    assign rd.payload = mem_reg[rp_reg];
    assign push       = wr.valid && wr.ready;
    assign pop        = rd.valid && rd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr.payload;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("fifo count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wp_reg != rp_reg)) else $error("fifo pointers out of step");
    a_ptr_eq: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd1) |-> (wp_reg == rp_reg)) else $error("fifo pointers out of step");
`endif

endmodule

// ===== rtl/core/shbh_back.sv =====
`timescale 1ns / 1ps
module shbh_back
    import shbh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    shbh_stream_if.sink   q,
    shbh_stream_if.source digest
);

    localparam logic [1:0] B_LOAD  = 2'd0;
    localparam logic [1:0] B_ROUND = 2'd1;
    localparam logic [1:0] B_FEED  = 2'd2;
    localparam logic [1:0] B_OUT   = 2'd3;

    logic [1:0]  state_reg;
    logic [3:0]  ld_cnt_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        last_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16];
    q_item_t     qi;
    logic [31:0] t1, t2, w_new, s0, s1, big0, big1, ch, mj;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    assign qi      = q.payload;
    assign q.ready = (state_reg == B_LOAD);

    assign big1  = rotr(r_reg[4], 6) ^ rotr(r_reg[4], 11) ^ rotr(r_reg[4], 25);
    assign ch    = (r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]);
    assign t1    = r_reg[7] + big1 + ch + round_k(rnd_reg) + w_reg[0];
    assign big0  = rotr(r_reg[0], 2) ^ rotr(r_reg[0], 13) ^ rotr(r_reg[0], 22);
    assign mj    = (r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]);
    assign t2    = big0 + mj;
    assign s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;

    assign digest.valid   = (state_reg == B_OUT);
    assign digest.payload = '{digest_word: chain_reg[0], word_index: idx_reg,
                              digest_last: (idx_reg == 3'd7)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_LOAD;
            ld_cnt_reg <= 4'd0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
            last_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV_WORDS[255 - 32 * i -: 32];
            end
        end
        else
        begin
            unique case (state_reg)
                B_LOAD:
                begin
                    if (q.valid)
                    begin
                        ld_cnt_reg <= ld_cnt_reg + 4'd1;
                        if (ld_cnt_reg == 4'd15)
                        begin
                            last_reg  <= qi.last;
                            rnd_reg   <= 6'd0;
                            state_reg <= B_ROUND;
                        end
                    end
                end
                B_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= B_FEED;
                    end
                end
                B_FEED:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + r_reg[i];
                    end
                    idx_reg   <= 3'd0;
                    state_reg <= last_reg ? B_OUT : B_LOAD;
                end
                B_OUT:
                begin
                    if (digest.ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= IV_WORDS[255 - 32 * i -: 32];
                            end
                            state_reg <= B_LOAD;
                        end
                        else
                        begin
                            for (int i = 0; i < 7; i++)
                            begin
                                chain_reg[i] <= chain_reg[i + 1];
                            end
                            chain_reg[7] <= chain_reg[0];
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_LOAD) && q.valid)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= qi.word;
            if (ld_cnt_reg == 4'd15)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    r_reg[i] <= chain_reg[i];
                end
            end
        end
        else if (state_reg == B_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            r_reg[7]  <= r_reg[6];
            r_reg[6]  <= r_reg[5];
            r_reg[5]  <= r_reg[4];
            r_reg[4]  <= r_reg[3] + t1;
            r_reg[3]  <= r_reg[2];
            r_reg[2]  <= r_reg[1];
            r_reg[1]  <= r_reg[0];
            r_reg[0]  <= t1 + t2;
        end
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_LOAD) |=> $stable(ld_cnt_reg)) else $error("load count moved");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ROUND && rnd_reg == 6'd63) |=> (state_reg == B_FEED))
        else $error("round sequence broken");
    a_out_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FEED && !last_reg) |=> (state_reg == B_LOAD))
        else $error("digest for inner block");
`endif

endmodule
